### hw/rtl/i2csbe_pkg.sv
// i2csbe_pkg: beat types, event codes and widths for the I2C slave bit engine.
// No dependencies; used by i2csbe_core and i2c_slave_bit_engine.
`timescale 1ns / 1ps

package i2csbe_pkg;

  localparam int ADDR_W       = 7;
  localparam int BYTE_W       = 8;
  localparam int BYTE_COUNT_W = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  // byte address of the own_address register
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_ADDRESS = 3'd0;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_START       = 3'd1,
    EV_WRITE_MATCH = 3'd2,
    EV_READ_MATCH  = 3'd3,
    EV_MISMATCH    = 3'd4,
    EV_BYTE_IN     = 3'd5,
    EV_MASTER_NACK = 3'd6,
    EV_STOP        = 3'd7
  } event_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic [BYTE_W-1:0] tx_data;
  } in_item_t;

  typedef struct packed {
    logic                    sda_pull_low;
    logic [BYTE_W-1:0]       rx_byte;
    logic                    tx_request;
    logic [2:0]              event_code;
    logic [BYTE_COUNT_W-1:0] byte_count;
  } out_item_t;

endpackage

### hw/rtl/i2c_slave_bit_engine.sv
// I2C slave bit engine with a 7-bit own address. Takes one sampled SCL/SDA pair
// per beat, detects start and stop, matches the address, acks, receives bytes in
// write transfers and shifts out tx_data bytes in read transfers, MSB first. One
// result beat per input beat. Throughput is one beat per clock unless stalled.
// Each accepted beat goes through the input register, then the state update into
// the result register in i2csbe_core. The own_address register sits at byte
// address 0 of the APB-style port; the user must write it only while the engine
// is idle; the engine does not enforce it. Depends on i2csbe_pkg and i2csbe_core.
`timescale 1ns / 1ps

module i2c_slave_bit_engine #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  i2csbe_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output i2csbe_pkg::out_item_t                 out_data,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [i2csbe_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [i2csbe_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [i2csbe_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);

  i2csbe_pkg::in_item_t              in_r;
  logic                              in_valid_r;
  logic                              out_valid_r;
  logic [i2csbe_pkg::ADDR_W-1:0]     own_addr_r;
  logic                              step;
  logic                              in_take;

  // advance when the result register is free or being drained
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == i2csbe_pkg::REG_OWN_ADDRESS) begin
      own_addr_r <= cfg_pwdata[i2csbe_pkg::ADDR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == i2csbe_pkg::REG_OWN_ADDRESS)
                      ? {{(i2csbe_pkg::CFG_DATA_W-i2csbe_pkg::ADDR_W){1'b0}}, own_addr_r}
                      : '0;

  i2csbe_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step),
    .item        (in_r),
    .own_address (own_addr_r),
    .res_r       (out_data)
  );

  assign out_valid = out_valid_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("result beat dropped while stalled");

  a_held_input_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_r))
    else $error("held input beat lost");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed beat did not reach the result register");

endmodule

### hw/rtl/i2csbe_core.sv
// i2csbe_core: bus state machine of the I2C slave bit engine, one sample pair per step.
// Holds the bus state and the result register; depends on i2csbe_pkg.
`timescale 1ns / 1ps

module i2csbe_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  i2csbe_pkg::in_item_t              item,
  input  logic [i2csbe_pkg::ADDR_W-1:0]     own_address,
  output i2csbe_pkg::out_item_t             res_r
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_ACK_OUT = 3'd2,
    PH_RX      = 3'd3,
    PH_TX      = 3'd4,
    PH_TX_ACK  = 3'd5,
    PH_WAIT    = 3'd6
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic                                prev_scl_r, prev_sda_r;
  logic [3:0]                          bit_cnt_r, bit_cnt_nxt;
  logic [i2csbe_pkg::BYTE_W-1:0]       shift_r, shift_nxt;
  logic                                dir_read_r, dir_read_nxt;
  logic [COUNT_BITS-1:0]               moved_r, moved_nxt, moved_inc;
  logic                                drive_low_r, drive_low_nxt;
  i2csbe_pkg::out_item_t               res_nxt;
  logic [i2csbe_pkg::BYTE_COUNT_W-1:0] count_out;

  logic                          scl, sda, rise, fall, scl_hi;
  logic [3:0]                    cnt_inc;
  logic [i2csbe_pkg::BYTE_W-1:0] shift_in;
  logic [2:0]                    ev;
  logic [i2csbe_pkg::BYTE_W-1:0] rxb;
  logic                          txreq;

  assign scl      = item.scl_level;
  assign sda      = item.sda_level;
  assign rise     = !prev_scl_r && scl;
  assign fall     = prev_scl_r && !scl;
  assign scl_hi   = prev_scl_r && scl;
  assign cnt_inc  = bit_cnt_r + 4'd1;
  assign shift_in = {shift_r[i2csbe_pkg::BYTE_W-2:0], sda};
  // hold at all ones
  assign moved_inc = (&moved_r) ? moved_r : moved_r + COUNT_BITS'(1);

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    dir_read_nxt  = dir_read_r;
    moved_nxt     = moved_r;
    drive_low_nxt = drive_low_r;
    ev            = i2csbe_pkg::EV_NONE;
    rxb           = '0;
    txreq         = 1'b0;

    priority if (scl_hi && prev_sda_r && !sda) begin
      // start or repeated start
      ev            = i2csbe_pkg::EV_START;
      phase_nxt     = PH_ADDR;
      bit_cnt_nxt   = 4'd0;
      shift_nxt     = '0;
      moved_nxt     = '0;
      drive_low_nxt = 1'b0;
    end else if (scl_hi && !prev_sda_r && sda) begin
      ev            = i2csbe_pkg::EV_STOP;
      phase_nxt     = PH_IDLE;
      bit_cnt_nxt   = 4'd0;
      drive_low_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_IDLE, PH_WAIT: begin
        end
        PH_ADDR: begin
          if (rise) begin
            shift_nxt   = shift_in;
            bit_cnt_nxt = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              bit_cnt_nxt = 4'd8;
              if (shift_in[7:1] == own_address) begin
                dir_read_nxt = shift_in[0];
                ev = shift_in[0] ? i2csbe_pkg::EV_READ_MATCH : i2csbe_pkg::EV_WRITE_MATCH;
                phase_nxt = PH_ACK_OUT;
              end else begin
                ev        = i2csbe_pkg::EV_MISMATCH;
                phase_nxt = PH_WAIT;
              end
            end
          end
        end
        PH_ACK_OUT: begin
          if (fall) begin
            if (bit_cnt_r == 4'd8) begin
              drive_low_nxt = 1'b1;
              bit_cnt_nxt   = 4'd9;
            end else begin
              bit_cnt_nxt = 4'd0;
              if (dir_read_r) begin
                phase_nxt     = PH_TX;
                txreq         = 1'b1;
                shift_nxt     = item.tx_data;
                drive_low_nxt = !item.tx_data[7];
              end else begin
                phase_nxt     = PH_RX;
                shift_nxt     = '0;
                drive_low_nxt = 1'b0;
              end
            end
          end
        end
        PH_RX: begin
          if (rise) begin
            shift_nxt   = shift_in;
            bit_cnt_nxt = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              bit_cnt_nxt = 4'd8;
              ev          = i2csbe_pkg::EV_BYTE_IN;
              rxb         = shift_in;
              moved_nxt   = moved_inc;
              phase_nxt   = PH_ACK_OUT;
            end
          end
        end
        PH_TX: begin
          if (rise) begin
            bit_cnt_nxt = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              bit_cnt_nxt = 4'd8;
              moved_nxt   = moved_inc;
              phase_nxt   = PH_TX_ACK;
            end
          end else if (fall && bit_cnt_r >= 4'd1) begin
            // advance to the next data bit
            shift_nxt     = {shift_r[i2csbe_pkg::BYTE_W-2:0], 1'b0};
            drive_low_nxt = !shift_r[6];
          end
        end
        PH_TX_ACK: begin
          if (fall && bit_cnt_r == 4'd8) begin
            drive_low_nxt = 1'b0;
            bit_cnt_nxt   = 4'd9;
          end else if (rise && bit_cnt_r == 4'd9) begin
            if (!sda) begin
              bit_cnt_nxt = 4'd10;
            end else begin
              ev          = i2csbe_pkg::EV_MASTER_NACK;
              phase_nxt   = PH_WAIT;
              bit_cnt_nxt = 4'd0;
            end
          end else if (fall && bit_cnt_r == 4'd10) begin
            phase_nxt     = PH_TX;
            bit_cnt_nxt   = 4'd0;
            txreq         = 1'b1;
            shift_nxt     = item.tx_data;
            drive_low_nxt = !item.tx_data[7];
          end
        end
        default: begin
          phase_nxt     = PH_IDLE;
          drive_low_nxt = 1'b0;
        end
      endcase
    end
  end

  // fit the transfer count to the 16-bit output field: clamp if wider, zero-extend if narrower
  generate
    if (COUNT_BITS > i2csbe_pkg::BYTE_COUNT_W) begin : g_sat
      assign count_out = (|moved_nxt[COUNT_BITS-1:i2csbe_pkg::BYTE_COUNT_W])
                         ? '1 : moved_nxt[i2csbe_pkg::BYTE_COUNT_W-1:0];
    end else if (COUNT_BITS == i2csbe_pkg::BYTE_COUNT_W) begin : g_eq
      assign count_out = moved_nxt;
    end else begin : g_ext
      assign count_out = {{(i2csbe_pkg::BYTE_COUNT_W-COUNT_BITS){1'b0}}, moved_nxt};
    end
  endgenerate

  always_comb begin
    res_nxt.sda_pull_low = drive_low_nxt;
    res_nxt.rx_byte      = rxb;
    res_nxt.tx_request   = txreq;
    res_nxt.event_code   = ev;
    res_nxt.byte_count   = count_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      prev_scl_r  <= 1'b1;
      prev_sda_r  <= 1'b1;
      bit_cnt_r   <= 4'd0;
      shift_r     <= '0;
      dir_read_r  <= 1'b0;
      moved_r     <= '0;
      drive_low_r <= 1'b0;
      res_r       <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      prev_scl_r  <= scl;
      prev_sda_r  <= sda;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      dir_read_r  <= dir_read_nxt;
      moved_r     <= moved_nxt;
      drive_low_r <= drive_low_nxt;
      res_r       <= res_nxt;
    end
  end

  a_txreq_enters_tx: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.tx_request |-> phase_r == PH_TX)
    else $error("tx_request without entering the transmit phase");

  a_rx_byte_only_on_byte_in: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.rx_byte != '0 |-> res_r.event_code == i2csbe_pkg::EV_BYTE_IN)
    else $error("rx_byte nonzero outside a byte-in event");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.event_code == i2csbe_pkg::EV_START |->
      phase_r == PH_ADDR && moved_r == '0 && !drive_low_r)
    else $error("start did not restart address reception");

  a_stop_releases: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.event_code == i2csbe_pkg::EV_STOP |-> phase_r == PH_IDLE && !res_r.sda_pull_low)
    else $error("stop did not release SDA and go idle");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd10)
    else $error("bit counter out of range");

endmodule

### tb/i2c_slave_bit_engine_tb.sv
// Self-checking testbench for i2c_slave_bit_engine: drives bus-level SCL/SDA sample beats
// and checks every result beat against an in-bench model of the engine.
// Depends on i2csbe_pkg and the i2c_slave_bit_engine RTL.
`timescale 1ns / 1ps

module i2c_slave_bit_engine_tb;

  // narrow counter width exercises the zero-extended byte count
  localparam int COUNT_BITS       = 8;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_OFF_LEN     = 300;
  localparam int SAMPLES_PER_MODE = 110;

  typedef enum logic [2:0] {
    BUS_IDLE, BUS_ADDR, BUS_ACK_OUT, BUS_RX, BUS_TX, BUS_TX_ACK, BUS_IGNORE
  } bus_phase_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  i2csbe_pkg::in_item_t              in_data;
  logic                              out_valid;
  logic                              out_stall;
  i2csbe_pkg::out_item_t             out_data;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [i2csbe_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [i2csbe_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [i2csbe_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                              cfg_pready;

  // engine model state
  logic [i2csbe_pkg::ADDR_W-1:0] own_address_q;
  logic                          prev_scl_q;
  logic                          prev_sda_q;
  bus_phase_t                    phase_q;
  logic [3:0]                    bit_cnt_q;
  logic [7:0]                    shift_q;
  logic                          dir_read_q;
  logic [COUNT_BITS-1:0]         moved_q;
  logic                          drive_low_q;

  i2csbe_pkg::out_item_t expected_results[$];
  i2csbe_pkg::out_item_t want_beat;
  int        fail_count = 0;
  int        samples_sent = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        fast_bits = 1'b0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  i2c_slave_bit_engine #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reset_engine_model();
    own_address_q = '0;
    prev_scl_q    = 1'b1;
    prev_sda_q    = 1'b1;
    phase_q       = BUS_IDLE;
    bit_cnt_q     = '0;
    shift_q       = '0;
    dir_read_q    = 1'b0;
    moved_q       = '0;
    drive_low_q   = 1'b0;
  endtask

  // Advance the engine model by one sample beat and return the result beat it causes.
  function automatic i2csbe_pkg::out_item_t predict_engine(i2csbe_pkg::in_item_t beat);
    i2csbe_pkg::out_item_t r;
    logic                  scl;
    logic                  sda;
    logic                  rise;
    logic                  fall;
    logic                  scl_hi;
    i2csbe_pkg::event_t    ev_code;
    logic [7:0]            rxb;
    logic                  txreq;
    logic [63:0]           mc;
    scl     = beat.scl_level;
    sda     = beat.sda_level;
    rise    = !prev_scl_q && scl;
    fall    = prev_scl_q && !scl;
    scl_hi  = prev_scl_q && scl;
    ev_code = i2csbe_pkg::EV_NONE;
    rxb     = '0;
    txreq   = 1'b0;

    if (scl_hi && prev_sda_q && !sda) begin
      ev_code     = i2csbe_pkg::EV_START;
      phase_q     = BUS_ADDR;
      bit_cnt_q   = '0;
      shift_q     = '0;
      moved_q     = '0;
      drive_low_q = 1'b0;
    end else if (scl_hi && !prev_sda_q && sda) begin
      ev_code     = i2csbe_pkg::EV_STOP;
      phase_q     = BUS_IDLE;
      bit_cnt_q   = '0;
      drive_low_q = 1'b0;
    end else begin
      case (phase_q)
        BUS_ADDR: begin
          if (rise) begin
            shift_q   = {shift_q[6:0], sda};
            bit_cnt_q = bit_cnt_q + 1'b1;
            if (bit_cnt_q >= 4'd8) begin
              bit_cnt_q = 4'd8;
              if (shift_q[7:1] == own_address_q) begin
                dir_read_q = shift_q[0];
                ev_code    = dir_read_q ? i2csbe_pkg::EV_READ_MATCH
                                        : i2csbe_pkg::EV_WRITE_MATCH;
                phase_q    = BUS_ACK_OUT;
              end else begin
                ev_code = i2csbe_pkg::EV_MISMATCH;
                phase_q = BUS_IGNORE;
              end
            end
          end
        end
        BUS_ACK_OUT: begin
          if (fall) begin
            if (bit_cnt_q == 4'd8) begin
              drive_low_q = 1'b1;
              bit_cnt_q   = 4'd9;
            end else begin
              bit_cnt_q = '0;
              if (dir_read_q) begin
                phase_q     = BUS_TX;
                txreq       = 1'b1;
                shift_q     = beat.tx_data;
                drive_low_q = !shift_q[7];
              end else begin
                phase_q     = BUS_RX;
                shift_q     = '0;
                drive_low_q = 1'b0;
              end
            end
          end
        end
        BUS_RX: begin
          if (rise) begin
            shift_q   = {shift_q[6:0], sda};
            bit_cnt_q = bit_cnt_q + 1'b1;
            if (bit_cnt_q >= 4'd8) begin
              bit_cnt_q = 4'd8;
              ev_code   = i2csbe_pkg::EV_BYTE_IN;
              rxb       = shift_q;
              if (moved_q != '1) moved_q = moved_q + 1'b1;
              phase_q   = BUS_ACK_OUT;
            end
          end
        end
        BUS_TX: begin
          if (rise) begin
            bit_cnt_q = bit_cnt_q + 1'b1;
            if (bit_cnt_q >= 4'd8) begin
              bit_cnt_q = 4'd8;
              if (moved_q != '1) moved_q = moved_q + 1'b1;
              phase_q   = BUS_TX_ACK;
            end
          end else if (fall && bit_cnt_q >= 4'd1) begin
            shift_q     = {shift_q[6:0], 1'b0};
            drive_low_q = !shift_q[7];
          end
        end
        BUS_TX_ACK: begin
          if (fall && bit_cnt_q == 4'd8) begin
            drive_low_q = 1'b0;
            bit_cnt_q   = 4'd9;
          end else if (rise && bit_cnt_q == 4'd9) begin
            if (!sda) begin
              bit_cnt_q = 4'd10;
            end else begin
              ev_code   = i2csbe_pkg::EV_MASTER_NACK;
              phase_q   = BUS_IGNORE;
              bit_cnt_q = '0;
            end
          end else if (fall && bit_cnt_q == 4'd10) begin
            phase_q     = BUS_TX;
            bit_cnt_q   = '0;
            txreq       = 1'b1;
            shift_q     = beat.tx_data;
            drive_low_q = !shift_q[7];
          end
        end
        default: ;
      endcase
    end

    prev_scl_q = scl;
    prev_sda_q = sda;

    mc             = 64'(moved_q);
    r.sda_pull_low = drive_low_q;
    r.rx_byte      = rxb;
    r.tx_request   = txreq;
    r.event_code   = ev_code;
    r.byte_count   = (mc > 64'hFFFF) ? 16'hFFFF : mc[15:0];
    return r;
  endfunction

  function automatic int level_len();
    if (fast_bits) return 1;
    return ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
  endfunction

  // Offer one sample beat, hold it until accepted, then queue its prediction.
  task automatic send_sample(input logic scl, input logic sda);
    i2csbe_pkg::in_item_t beat;
    beat.scl_level = scl;
    beat.sda_level = sda;
    beat.tx_data   = 8'($urandom);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_engine(beat));
    samples_sent++;
  endtask

  task automatic bus_bit(input logic b);
    repeat (level_len()) send_sample(1'b0, b);
    repeat (level_len()) send_sample(1'b1, b);
  endtask

  task automatic bus_byte(input logic [7:0] value, input logic ack);
    for (int i = 7; i >= 0; i--) bus_bit(value[i]);
    bus_bit(ack);
  endtask

  task automatic bus_start();
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_own_address(input logic [i2csbe_pkg::ADDR_W-1:0] value);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= i2csbe_pkg::REG_OWN_ADDRESS;
    cfg_pwdata  <= i2csbe_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    own_address_q = value;
  endtask

  task automatic random_transfer();
    int                            kind;
    int                            n;
    logic [i2csbe_pkg::ADDR_W-1:0] addr;
    kind = $urandom_range(9);
    n    = $urandom_range(0, 4);
    case (kind)
      0: repeat ($urandom_range(1, 20)) send_sample(1'($urandom), 1'($urandom));
      1: begin
        bus_start();
        addr = own_address_q ^ 7'($urandom_range(1, 127));
        bus_byte({addr, 1'($urandom)}, 1'($urandom));
        repeat (n) bus_byte(8'($urandom), 1'($urandom));
      end
      2, 3, 4, 5: begin
        bus_start();
        bus_byte({own_address_q, 1'b0}, 1'($urandom));
        repeat (n) bus_byte(8'($urandom), 1'b0);
      end
      6, 7, 8: begin
        bus_start();
        bus_byte({own_address_q, 1'b1}, 1'($urandom));
        repeat (n) bus_byte(8'($urandom), 1'b0);
        bus_byte(8'($urandom), 1'b1);
      end
      default: begin
        // broken frame: cut short by the next start or stop
        bus_start();
        repeat ($urandom_range(0, 20)) bus_bit(1'($urandom));
      end
    endcase
    if ($urandom_range(3) != 0) bus_stop();
  endtask

  task automatic test_reset_address();
    bus_start();
    bus_byte({7'h00, 1'b0}, 1'b0);
    bus_byte(8'h3C, 1'b0);
    bus_stop();
  endtask

  task automatic test_directed_frames();
    set_own_address(7'h7F);
    bus_start();
    bus_byte({7'h7F, 1'b0}, 1'b0);
    bus_byte(8'h00, 1'b0);
    bus_byte(8'hFF, 1'b0);
    // repeated start into a read, acked once, then master nack
    bus_start();
    bus_byte({7'h7F, 1'b1}, 1'b0);
    bus_byte(8'hA5, 1'b0);
    bus_byte(8'h5A, 1'b1);
    bus_bit(1'b1);
    bus_stop();
    bus_start();
    bus_byte({7'h7E, 1'b0}, 1'b0);
    bus_bit(1'b0);
    bus_stop();
    // stop in the middle of a received byte
    bus_start();
    bus_byte({7'h7F, 1'b0}, 1'b0);
    repeat (3) bus_bit(1'b1);
    bus_stop();
    // start in the middle of a sent byte
    bus_start();
    bus_byte({7'h7F, 1'b1}, 1'b0);
    repeat (4) bus_bit(1'b0);
    bus_start();
    bus_stop();
  endtask

  task automatic test_random_mode(input int idle_pct, input int stall_rate,
                                  input logic [i2csbe_pkg::ADDR_W-1:0] addr);
    int first;
    set_own_address(addr);
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    first         = samples_sent;
    while (samples_sent - first < SAMPLES_PER_MODE) random_transfer();
    bus_stop();
  endtask

  task automatic test_backpressure();
    set_own_address(7'($urandom));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    bus_start();
    bus_byte({own_address_q, 1'b0}, 1'b0);
    repeat (4) bus_byte(8'($urandom), 1'b0);
    bus_stop();
    wait_drained();
  endtask

  task automatic test_long_transfer();
    set_own_address(7'h2A);
    send_idle_pct = 0;
    stall_pct     = 10;
    fast_bits     = 1'b1;
    bus_start();
    bus_byte({7'h2A, 1'b0}, 1'b0);
    repeat (4) bus_byte(8'($urandom), 1'b0);
    bus_stop();
    bus_start();
    bus_byte({7'h2A, 1'b1}, 1'b0);
    repeat (4) bus_byte(8'($urandom), 1'b0);
    bus_byte(8'($urandom), 1'b1);
    bus_stop();
    fast_bits = 1'b0;
  endtask

  // receiver: random stall, or a counted hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_OFF_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation pending: %h", out_data);
        fail_count++;
      end else begin
        want_beat = expected_results.pop_front();
        if (out_data.sda_pull_low !== want_beat.sda_pull_low) begin
          $error("sda_pull_low expected %0d actual %0d",
                 want_beat.sda_pull_low, out_data.sda_pull_low);
          fail_count++;
        end
        if (out_data.rx_byte !== want_beat.rx_byte) begin
          $error("rx_byte expected %0h actual %0h", want_beat.rx_byte, out_data.rx_byte);
          fail_count++;
        end
        if (out_data.tx_request !== want_beat.tx_request) begin
          $error("tx_request expected %0d actual %0d",
                 want_beat.tx_request, out_data.tx_request);
          fail_count++;
        end
        if (out_data.event_code !== want_beat.event_code) begin
          $error("event_code expected %0d actual %0d",
                 want_beat.event_code, out_data.event_code);
          fail_count++;
        end
        if (out_data.byte_count !== want_beat.byte_count) begin
          $error("byte_count expected %0d actual %0d",
                 want_beat.byte_count, out_data.byte_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    reset_engine_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_address();
    test_directed_frames();
    test_random_mode(0, 0, 7'h00);
    test_random_mode(85, 0, 7'h7F);
    test_random_mode(0, 85, 7'($urandom));
    test_random_mode(18, 18, 7'($urandom));
    test_backpressure();
    test_long_transfer();

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/i2csbe_pkg.sv
hw/rtl/i2csbe_core.sv
hw/rtl/i2c_slave_bit_engine.sv
tb/i2c_slave_bit_engine_tb.sv
